// ===== sv/ueru_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package ueru_pkg;

  // Width of a configuration register index and of its write data.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_TICKS       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CM          = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE_CODE = 4'd3;

  // Register values after reset.
  localparam logic [9:0] RST_TRIGGER_TICKS     = 10'd192;
  localparam logic [9:0] RST_GUARD_TICKS       = 10'd320;
  localparam logic [7:0] RST_LIMIT_CM          = 8'd200;
  localparam logic [7:0] RST_OUT_OF_RANGE_CODE = 8'd205;

  // Distance scale: centimeters = ticks * CM_NUM / CM_DEN.
  localparam int REM_W  = 24;
  localparam int QUOT_W = 9;
  localparam logic [14:0]      CM_NUM = 15'd17013;
  localparam logic [REM_W-1:0] CM_DEN = 24'd16000000;

  typedef struct packed {
    logic start_req;
    logic echo;
  } req_t;

  typedef struct packed {
    logic       trigger;
    logic       busy_res;
    logic [7:0] distance_cm;
    logic       done_res;
  } res_t;

  typedef struct packed {
    logic [9:0] trigger_ticks;
    logic [9:0] guard_ticks;
    logic [7:0] limit_cm;
    logic [7:0] out_of_range_code;
  } cfg_t;

  // Controls from the sequencer to the echo distance tracker.
  typedef struct packed {
    logic clear;
    logic count;
  } dist_ctl_t;

endpackage

// ===== sv/ueru_if.sv =====
// Channel interfaces for requests, results and configuration writes.
interface ueru_req_if;
  logic          valid;
  logic          ready;
  ueru_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ueru_res_if;
  logic          valid;
  logic          ready;
  ueru_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ueru_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ueru_pkg::CFG_IDX_W-1:0]   index;
  logic [ueru_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ultrasonic_echo_ranger_unit.sv =====
// Top level of the ultrasonic echo ranger: request and result registers around the sequencer.
// A request is first held in the input register; its result is then loaded into the
// result register, which offers it on the result channel.
// Throughput: one request per cycle while results are taken; the input register and the
// result register each hold one item, so a stalled result lets one more request in before
// the input stalls. Reset: synchronous; the phase returns to idle, counters clear,
// registers take their default values. There is no clearing pass.
module ultrasonic_echo_ranger_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  ueru_req_if.sink  req,
  ueru_res_if.source res,
  ueru_cfg_if.sink  cfg
);

  ueru_pkg::cfg_t      regs;
  ueru_pkg::req_t      req_q;
  logic                req_full;
  logic                step;
  ueru_pkg::dist_ctl_t dctl;
  ueru_pkg::res_t      result;
  logic [7:0]          distance;

  // A buffered request is processed when the result register can take it.
  assign step      = req_full && (!res.valid || res.ready);
  assign req.ready = !req_full || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_full <= 1'b1;
    end else if (step) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.data <= result;
    end
  end

  ueru_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ueru_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (req_q),
    .regs     (regs),
    .distance (distance),
    .dctl     (dctl),
    .result   (result)
  );

  ueru_dist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .ctl      (dctl),
    .regs     (regs),
    .distance (distance)
  );

  // A done result always comes from a busy sequencer.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.done_res |-> res.data.busy_res)
    else $error("done result reported while not busy");

  // The trigger is only driven during a measurement.
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.trigger |-> res.data.busy_res)
    else $error("trigger driven while idle");

  // A measurement cannot finish during the trigger pulse.
  a_trig_not_done: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.data.trigger && res.data.done_res))
    else $error("done reported during the trigger pulse");

endmodule

// ===== sv/ueru_cfg_regs.sv =====
// Configuration register bank of the echo ranger.
module ueru_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  ueru_cfg_if.sink       cfg,
  output ueru_pkg::cfg_t regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register write decode; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trigger_ticks     <= ueru_pkg::RST_TRIGGER_TICKS;
      regs.guard_ticks       <= ueru_pkg::RST_GUARD_TICKS;
      regs.limit_cm          <= ueru_pkg::RST_LIMIT_CM;
      regs.out_of_range_code <= ueru_pkg::RST_OUT_OF_RANGE_CODE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ueru_pkg::REG_TRIGGER_TICKS:     regs.trigger_ticks     <= cfg.data;
        ueru_pkg::REG_GUARD_TICKS:       regs.guard_ticks       <= cfg.data;
        ueru_pkg::REG_LIMIT_CM:          regs.limit_cm          <= cfg.data[7:0];
        ueru_pkg::REG_OUT_OF_RANGE_CODE: regs.out_of_range_code <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ueru_dist.sv =====
// Echo tick counter that keeps the distance as a running quotient and remainder.
module ueru_dist #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  ueru_pkg::dist_ctl_t  ctl,
  input  ueru_pkg::cfg_t       regs,
  output logic [7:0]           distance
);

  logic [COUNT_WIDTH-1:0]      count;
  logic [COUNT_WIDTH-1:0]      count_next;
  logic [ueru_pkg::REM_W-1:0]  rem;
  logic [ueru_pkg::REM_W-1:0]  rem_next;
  logic [ueru_pkg::QUOT_W-1:0] quot;
  logic [ueru_pkg::QUOT_W-1:0] quot_next;
  logic [COUNT_WIDTH-1:0]      base_count;
  logic [ueru_pkg::REM_W-1:0]  base_rem;
  logic [ueru_pkg::QUOT_W-1:0] base_quot;
  logic [ueru_pkg::REM_W:0]    rem_sum;
  logic [ueru_pkg::REM_W:0]    rem_diff;
  logic                        out_of_range;

  // Each counted tick adds CM_NUM to the remainder; a remainder reaching CM_DEN
  // bumps the quotient, which sticks at its top value. A saturated count
  // stops the scaled value from growing.
  always_comb begin
    base_count = ctl.clear ? '0 : count;
    base_rem   = ctl.clear ? '0 : rem;
    base_quot  = ctl.clear ? '0 : quot;
    rem_sum    = {1'b0, base_rem} + {{(ueru_pkg::REM_W + 1 - 15){1'b0}}, ueru_pkg::CM_NUM};
    rem_diff   = rem_sum - {1'b0, ueru_pkg::CM_DEN};
    count_next = base_count;
    rem_next   = base_rem;
    quot_next  = base_quot;
    if (ctl.count && !(&base_count)) begin
      count_next = base_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      if (rem_sum >= {1'b0, ueru_pkg::CM_DEN}) begin
        rem_next  = rem_diff[ueru_pkg::REM_W-1:0];
        quot_next = (&base_quot) ? base_quot
                                 : base_quot + {{(ueru_pkg::QUOT_W-1){1'b0}}, 1'b1};
      end else begin
        rem_next = rem_sum[ueru_pkg::REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rem   <= '0;
      quot  <= '0;
    end else if (step) begin
      count <= count_next;
      rem   <= rem_next;
      quot  <= quot_next;
    end
  end

  // Out of range when the count is zero or the scaled count exceeds the
  // limit: the quotient is above it, or equal with a nonzero remainder.
  always_comb begin
    out_of_range = (count == '0)
                || (quot > {1'b0, regs.limit_cm})
                || ((quot == {1'b0, regs.limit_cm}) && (rem != '0));
    distance = out_of_range ? regs.out_of_range_code : quot[7:0];
  end

endmodule

// ===== sv/ueru_seq.sv =====
// Measurement sequencer: trigger timing, echo edge detection and results.
module ueru_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ueru_pkg::req_t      item,
  input  ueru_pkg::cfg_t      regs,
  input  logic [7:0]          distance,
  output ueru_pkg::dist_ctl_t dctl,
  output ueru_pkg::res_t      result
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_GUARD_PRE  = 3'd1;
  localparam logic [2:0] PH_TRIG       = 3'd2;
  localparam logic [2:0] PH_GUARD_POST = 3'd3;
  localparam logic [2:0] PH_LISTEN     = 3'd4;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [9:0] phase_ticks;
  logic [9:0] phase_ticks_next;
  logic       echo_active;
  logic       echo_active_next;
  logic       prev_echo;
  logic [9:0] tick_inc;
  logic [9:0] phase_len;
  logic       expired;
  logic       rise;
  logic       fall;

  // Timed phase length, whether it ends this tick, and the echo edges.
  always_comb begin
    phase_len = (phase == PH_TRIG) ? regs.trigger_ticks : regs.guard_ticks;
    tick_inc  = phase_ticks + 10'd1;
    expired   = tick_inc >= phase_len;
    rise      = item.echo && !prev_echo;
    fall      = echo_active && !item.echo && prev_echo;
  end

  // Phase transitions and result for one tick.
  always_comb begin
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    echo_active_next   = echo_active;
    dctl               = '0;
    result.trigger     = (phase == PH_TRIG);
    result.busy_res    = (phase != PH_IDLE);
    result.distance_cm = 8'd0;
    result.done_res    = 1'b0;
    unique case (phase) inside
      PH_IDLE: begin
        if (item.start_req) begin
          phase_next       = PH_GUARD_PRE;
          phase_ticks_next = '0;
          echo_active_next = 1'b0;
          dctl.clear       = 1'b1;
        end
      end
      PH_GUARD_PRE, PH_TRIG, PH_GUARD_POST: begin
        if (expired) begin
          phase_ticks_next = '0;
          phase_next = (phase == PH_GUARD_PRE) ? PH_TRIG :
                       (phase == PH_TRIG)      ? PH_GUARD_POST : PH_LISTEN;
        end else begin
          phase_ticks_next = tick_inc;
        end
      end
      PH_LISTEN: begin
        dctl.clear = rise;
        dctl.count = (echo_active || rise) && item.echo;
        echo_active_next = echo_active || rise;
        if (fall) begin
          result.distance_cm = distance;
          result.done_res    = 1'b1;
          echo_active_next   = 1'b0;
          phase_next         = PH_IDLE;
          phase_ticks_next   = '0;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_ticks <= '0;
      echo_active <= 1'b0;
      prev_echo   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      phase_ticks <= phase_ticks_next;
      echo_active <= echo_active_next;
      prev_echo   <= item.echo;
    end
  end

  // A completed measurement always returns the sequencer to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.done_res |=> phase == PH_IDLE)
    else $error("sequencer did not return to idle after a result");

  // Echo tracking is only armed while listening.
  a_active_listen: assert property (@(posedge clk) disable iff (rst)
    echo_active |-> phase == PH_LISTEN)
    else $error("echo tracking armed outside the listening phase");

  // The counter never runs while idle.
  a_no_count_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !dctl.count)
    else $error("echo counter enabled while idle");

endmodule
